// File: rtl/adc_to_voltage_seven_segment_defines.svh
// Assertion macros shared by the display block.
// Included by the top level only; no other dependencies.
`ifndef ADC_TO_VOLTAGE_SEVEN_SEGMENT_DEFINES_SVH
`define ADC_TO_VOLTAGE_SEVEN_SEGMENT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define A2VSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("display block check failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define A2VSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("display block check failed");
`else
`define A2VSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define A2VSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/a2vss_pkg.sv
// Types, constants and lookup functions for the voltage display block.
// No dependencies; used by every module of the block.
`default_nettype none

package a2vss_pkg;

    localparam int unsigned SAMPLE_W     = 10;
    localparam int unsigned SCALE_W      = 14;
    localparam int unsigned PRODUCT_W    = SAMPLE_W + SCALE_W;
    localparam int unsigned VALUE_W      = 14;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SCALE_W-1:0] FULL_SCALE_RESET = 14'd500;
    localparam logic [VALUE_W-1:0] VALUE_LIMIT      = 14'd9999;
    localparam logic [10:0]        DIVISOR          = 11'd1023;

    // Digit positions, ones first.
    localparam logic [1:0] DIG_ONES      = 2'd0;
    localparam logic [1:0] DIG_TENS      = 2'd1;
    localparam logic [1:0] DIG_HUNDREDS  = 2'd2;
    localparam logic [1:0] DIG_THOUSANDS = 2'd3;

    localparam logic [3:0] SEL_ONES      = 4'b1110;
    localparam logic [3:0] SEL_TENS      = 4'b1101;
    localparam logic [3:0] SEL_HUNDREDS  = 4'b1011;
    localparam logic [3:0] SEL_THOUSANDS = 4'b0111;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    // One scaled value waiting to be shown, with the index of its top digit.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         last_idx;
    } a2vss_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic not_empty;
    } a2vss_qstat_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'hC0;
            4'd1:    pattern = 8'hF9;
            4'd2:    pattern = 8'hA4;
            4'd3:    pattern = 8'hB0;
            4'd4:    pattern = 8'h99;
            4'd5:    pattern = 8'h92;
            4'd6:    pattern = 8'h82;
            4'd7:    pattern = 8'hF8;
            4'd8:    pattern = 8'h80;
            4'd9:    pattern = 8'h90;
            default: pattern = SEG_BLANK;
        endcase
        return pattern;
    endfunction

    function automatic logic [3:0] digit_sel(input logic [1:0] idx);
        logic [3:0] sel;
        case (idx)
            DIG_ONES:      sel = SEL_ONES;
            DIG_TENS:      sel = SEL_TENS;
            DIG_HUNDREDS:  sel = SEL_HUNDREDS;
            DIG_THOUSANDS: sel = SEL_THOUSANDS;
            default:       sel = SEL_ONES;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// File: rtl/a2vss_front.sv
// Front part: accepts samples, scales them to hundredths of a volt and
// works out how many digits each shows. Depends on a2vss_pkg.
`default_nettype none

module a2vss_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [a2vss_pkg::SCALE_W-1:0]   full_scale,
    input  wire logic                            sample_valid,
    output logic                                 sample_stall,
    input  wire logic [a2vss_pkg::SAMPLE_W-1:0]  sample,
    input  wire a2vss_pkg::a2vss_qstat_t         qstat,
    output logic                                 push,
    output a2vss_pkg::a2vss_item_t               push_item
);
    import a2vss_pkg::*;

    logic                 prod_valid_reg;
    logic [PRODUCT_W-1:0] prod_reg;
    logic                 item_valid_reg;
    a2vss_item_t          item_reg;
    logic                 adv_prod;
    logic                 adv_item;

    logic [VALUE_W-1:0]   q_est;
    logic [14:0]          rem1;
    logic [4:0]           rem1_hi;
    logic [10:0]          rem2;
    logic [15:0]          quot;
    logic [VALUE_W-1:0]   value;
    logic [1:0]           last_idx;

    assign push     = item_valid_reg && !qstat.full;
    assign adv_item = !item_valid_reg || push;
    assign adv_prod = !prod_valid_reg || adv_item;
    assign sample_stall = !adv_prod;
    assign push_item = item_reg;

    // Division by 1023: p = 1024*q_est + lo = 1023*q_est + (lo + q_est),
    // and the remainder term is folded the same way once more.
    always_comb
    begin
        q_est   = prod_reg[PRODUCT_W-1:10];
        rem1    = 15'(prod_reg[9:0]) + 15'(q_est);
        rem1_hi = rem1[14:10];
        rem2    = 11'(rem1[9:0]) + 11'(rem1_hi);
        quot    = 16'(q_est) + 16'(rem1_hi) + 16'(rem2 >= DIVISOR);
        if (quot > 16'(VALUE_LIMIT))
            value = VALUE_LIMIT;
        else
            value = quot[VALUE_W-1:0];
        if (value > 14'd999)
            last_idx = DIG_THOUSANDS;
        else if (value > 14'd99)
            last_idx = DIG_HUNDREDS;
        else if (value > 14'd9)
            last_idx = DIG_TENS;
        else
            last_idx = DIG_ONES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_prod)
                prod_valid_reg <= sample_valid;
            if (adv_item)
                item_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_prod && sample_valid)
            prod_reg <= PRODUCT_W'(full_scale) * PRODUCT_W'(sample);
        if (adv_item && prod_valid_reg)
        begin
            item_reg.value    <= value;
            item_reg.last_idx <= last_idx;
        end
    end

endmodule

`default_nettype wire

// File: rtl/a2vss_queue.sv
// Short queue of scaled values between the front and back parts.
// Depends on a2vss_pkg.
`default_nettype none

module a2vss_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire a2vss_pkg::a2vss_item_t push_item,
    input  wire logic                   pop,
    output a2vss_pkg::a2vss_item_t      head_item,
    output a2vss_pkg::a2vss_qstat_t     qstat
);
    import a2vss_pkg::*;

    a2vss_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic [QCOUNT_W-1:0] count_next;

    assign qstat.full      = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign head_item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCOUNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCOUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// File: rtl/a2vss_back.sv
// Back part: splits a scaled value into decimal digits, one a cycle when not
// stalled, and drives the registered display request. Depends on a2vss_pkg.
`default_nettype none

module a2vss_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire a2vss_pkg::a2vss_item_t head_item,
    input  wire a2vss_pkg::a2vss_qstat_t qstat,
    output logic                        pop,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [3:0]                  digit_select,
    output logic [7:0]                  segments,
    output logic                        last_digit
);
    import a2vss_pkg::*;

    logic                busy_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [1:0]          idx_reg;
    logic [1:0]          last_idx_reg;
    logic                out_valid_reg;
    logic [3:0]          sel_reg;
    logic [7:0]          seg_reg;
    logic                last_reg;

    logic                emit;
    logic                finish;
    logic [29:0]         recip_prod;
    logic [VALUE_W-1:0]  tenth;
    logic [VALUE_W-1:0]  tenth_x10;
    logic [3:0]          digit;

    // Exact divide by ten for values below 2^14: multiply by ceil(2^19/10).
    always_comb
    begin
        recip_prod = 30'(val_reg) * 30'd52429;
        tenth      = recip_prod[29:19] == '0 ? '0 : VALUE_W'(recip_prod[29:19]);
        tenth_x10  = VALUE_W'({tenth, 3'b000}) + VALUE_W'({tenth, 1'b0});
        digit      = 4'(val_reg - tenth_x10);
    end

    assign emit   = busy_reg && (!out_valid_reg || !result_stall);
    assign finish = emit && (idx_reg == last_idx_reg);
    assign pop    = qstat.not_empty && (!busy_reg || finish);

    assign result_valid = out_valid_reg;
    assign digit_select = sel_reg;
    assign segments     = seg_reg;
    assign last_digit   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            val_reg      <= head_item.value;
            last_idx_reg <= head_item.last_idx;
            idx_reg      <= DIG_ONES;
        end
        else if (emit)
        begin
            val_reg <= tenth;
            idx_reg <= idx_reg + 2'd1;
        end
        if (emit)
        begin
            sel_reg  <= digit_sel(idx_reg);
            seg_reg  <= seg_pattern(digit);
            last_reg <= finish;
        end
    end

endmodule

`default_nettype wire

// File: rtl/adc_to_voltage_seven_segment.sv
// Top level of the converter-sample to seven-segment voltage display.
// Depends on a2vss_pkg, the defines header, a2vss_front, a2vss_queue, a2vss_back.
//
//   Channel   Direction  Handshake                   Payload
//   sample    in         sample_valid/sample_stall   sample[9:0]
//   result    out        result_valid/result_stall   digit_select, segments, last_digit
//   config    in         cfg_write (no wait)         cfg_data[13:0] -> full_scale
//
// Each sample gives one to four result requests, one a cycle while result_stall
// is low, so a sample occupies the back part until all its digits are shown.
// A sample is multiplied into prod_reg, then scaled into item_reg, then pushed.
// Reset clears all valid flags and sets full_scale to 500; no clearing pass.
// A stall on the result side fills the two-entry queue and then the front
// stages before it raises sample_stall; the front runs on meanwhile.
`default_nettype none
`include "adc_to_voltage_seven_segment_defines.svh"

module adc_to_voltage_seven_segment (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [a2vss_pkg::SCALE_W-1:0]   cfg_data,
    input  wire logic                            sample_valid,
    output logic                                 sample_stall,
    input  wire logic [a2vss_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [3:0]                           digit_select,
    output logic [7:0]                           segments,
    output logic                                 last_digit
);
    import a2vss_pkg::*;

    // The full-scale register holds the shown value at converter code 1023.
    logic [SCALE_W-1:0] full_scale_reg;
    logic [SCALE_W-1:0] full_scale_next;

    logic               push;
    logic               pop;
    a2vss_item_t        push_item;
    a2vss_item_t        head_item;
    a2vss_qstat_t       qstat;

    assign full_scale_next = cfg_write ? cfg_data : full_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_scale_reg <= FULL_SCALE_RESET;
        else
            full_scale_reg <= full_scale_next;
    end

    // The front part scales the sample and decides how many digits to show.
    a2vss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .full_scale   (full_scale_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .qstat        (qstat),
        .push         (push),
        .push_item    (push_item)
    );

    // The queue lets the front keep accepting while the back is emitting digits.
    a2vss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // The back part emits the digits, ones first, through its output register.
    a2vss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .digit_select (digit_select),
        .segments     (segments),
        .last_digit   (last_digit)
    );

    // Digits of one sample follow each other without a gap.
    `A2VSS_ASSERT_NEXT(a_digits_contiguous, clk, rst_n, result_valid && !result_stall && !last_digit, result_valid)
    // Each following digit moves the select one place up.
    `A2VSS_ASSERT_NEXT(a_select_steps, clk, rst_n, result_valid && !result_stall && !last_digit, digit_select == {$past(digit_select[2:0]), 1'b1})
    // Every shown pattern keeps the decimal point dark.
    `A2VSS_ASSERT_NOW(a_point_dark, clk, rst_n, result_valid, segments[7])

endmodule

`default_nettype wire
